### hdl/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

	localparam int BlockW = 128;
	localparam int HalfW = 64;
	localparam int WordW = 32;
	localparam int CfgW = 64;
	localparam int CfgIdxW = 3;
	localparam int RkDepth = 60;
	localparam int RkAddrW = 6;

	localparam logic [CfgIdxW-1:0] REG_KEY_SIZE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY_0 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY_1 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY_2 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_KEY_3 = 3'd4;

	localparam logic [1:0] KEY_128 = 2'd0;
	localparam logic [1:0] KEY_192 = 2'd1;

	localparam logic OP_ENCRYPT = 1'b0;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] ISBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// Control from the sequencer to the round datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic decrypt;
		logic first;
		logic last;
	} rnd_ctl_t;

endpackage

### hdl/aes_stream_if.sv
`timescale 1ns / 1ps
interface aes_stream_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/aes_block_cipher.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload
// in_ch    in   operation, block_high, block_low (129 bits)
// out_ch   out  result_high, result_low (128 bits)
// The round-key store has one registered read port, so each round first fetches
// its four words and then the round unit does a whole round in a single step.
// After a write to the key size or key registers the next item first waits while
// the key schedule is expanded. Reset clears control and configuration only. The
// result is held until taken; a new item is accepted only once the previous result
// has left.
module aes_block_cipher import aes_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	aes_stream_if.sink in_ch,
	aes_stream_if.source out_ch,
	input  logic cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0] cfg_data
);
	typedef enum logic [2:0] {S_IDLE, S_KEY, S_INIT, S_FETCH, S_ROUND, S_OUT} st_t;
	st_t st_q;
	logic [1:0] ksize_q;
	logic [4*CfgW-1:0] key_q;
	logic stale_q, dec_q, kstart, kbusy;
	logic [3:0] rnd_q, nr;
	logic [2:0] cnt_q;
	logic [RkAddrW-1:0] raddr;
	logic [WordW-1:0] rword;
	logic [BlockW-1:0] rk_q, state;
	rnd_ctl_t ctl;

	assign nr = (ksize_q == KEY_128) ? 4'd10 : ((ksize_q == KEY_192) ? 4'd12 : 4'd14);
	assign raddr = RkAddrW'({rnd_q, 2'b00} + {3'd0, cnt_q[1:0]});
	assign kstart = (st_q == S_IDLE) && in_ch.valid && stale_q;
	assign in_ch.ready = (st_q == S_IDLE) && !stale_q;
	assign out_ch.valid = (st_q == S_OUT);
	assign out_ch.data = state;

	assign ctl.load = in_ch.valid && in_ch.ready;
	assign ctl.decrypt = dec_q;
	assign ctl.step = (st_q == S_ROUND);
	assign ctl.first = dec_q ? (rnd_q == nr) : (rnd_q == 4'd0);
	assign ctl.last = dec_q ? (rnd_q == 4'd0) : (rnd_q == nr);

	aes_key_expand u_key (
		.clk(clk), .arst_n(arst_n), .start(kstart), .key_size(ksize_q), .key(key_q),
		.rd_addr(raddr), .rd_word(rword), .busy(kbusy));

	aes_round u_rnd (
		.clk(clk), .ctl(ctl), .blk_in(in_ch.data[BlockW-1:0]), .rkey(rk_q), .state_q(state));

	// Configuration registers; any valid write makes the key schedule stale.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksize_q <= '0;
			key_q <= '0;
			stale_q <= 1'b1;
		end else begin
			if (cfg_we && cfg_index <= REG_KEY_3) stale_q <= 1'b1;
			else if (kstart) stale_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_SIZE: ksize_q <= cfg_data[1:0];
					REG_KEY_0: key_q[4*CfgW-1 -: CfgW] <= cfg_data;
					REG_KEY_1: key_q[3*CfgW-1 -: CfgW] <= cfg_data;
					REG_KEY_2: key_q[2*CfgW-1 -: CfgW] <= cfg_data;
					REG_KEY_3: key_q[CfgW-1 -: CfgW] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Round key assembled from the four fetched words.
	always_ff @(posedge clk) begin
		if (st_q == S_FETCH && cnt_q != 3'd0) rk_q <= {rk_q[BlockW-WordW-1:0], rword};
	end

	// Sequencer: expand a stale key schedule, then per round fetch four key words and do one round step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			rnd_q <= '0;
			cnt_q <= '0;
			dec_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (kstart) st_q <= S_KEY;
					else if (ctl.load) begin
						dec_q <= in_ch.data[BlockW] != OP_ENCRYPT;
						rnd_q <= (in_ch.data[BlockW] != OP_ENCRYPT) ? nr : 4'd0;
						cnt_q <= '0;
						st_q <= S_FETCH;
					end
				end
				S_KEY: if (!kbusy) st_q <= S_IDLE;
				S_INIT: st_q <= S_FETCH;
				S_FETCH: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) st_q <= S_ROUND;
				end
				S_ROUND: begin
					cnt_q <= '0;
					if (ctl.last) st_q <= S_OUT;
					else begin
						rnd_q <= dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
						st_q <= S_FETCH;
					end
				end
				S_OUT: if (out_ch.ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hdl/aes_key_expand.sv
`timescale 1ns / 1ps
module aes_key_expand import aes_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] key_size,
	input  logic [4*CfgW-1:0] key,
	input  logic [RkAddrW-1:0] rd_addr,
	output logic [WordW-1:0] rd_word,
	output logic busy
);
	// Round-key store, one word written per cycle while busy.
	logic [WordW-1:0] mem [RkDepth];
	logic [RkAddrW-1:0] idx_q;
	logic [WordW-1:0] prev_q;
	logic [WordW-1:0] back_q [8];
	logic [2:0] pos_q;
	logic [7:0] rc_q;
	logic [3:0] nk;
	logic [RkAddrW:0] total;
	logic [WordW-1:0] t, nw, kw;
	logic [2:0] hi;

	always_comb begin
		nk = (key_size == KEY_128) ? 4'd4 : ((key_size == KEY_192) ? 4'd6 : 4'd8);
		total = 7'(4 * (nk + 7));
		hi = 3'(7 - idx_q[2:0]);
		kw = key[WordW*hi +: WordW];
		t = prev_q;
		if (pos_q == 3'd0)
			t = sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rc_q, 24'h0};
		else if (nk == 4'd8 && pos_q == 3'd4)
			t = sub_word(prev_q);
		nw = (idx_q < RkAddrW'(nk)) ? kw : (back_q[3'(nk - 4'd1)] ^ t);
	end

	// Expansion walk: key words first, then the recurrence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			idx_q <= '0;
			pos_q <= '0;
			rc_q <= 8'h01;
		end else if (start) begin
			busy <= 1'b1;
			idx_q <= '0;
			pos_q <= '0;
			rc_q <= 8'h01;
		end else if (busy) begin
			if (idx_q >= RkAddrW'(nk) && pos_q == 3'd0) rc_q <= xt(rc_q);
			pos_q <= (pos_q == 3'(nk - 4'd1)) ? 3'd0 : pos_q + 3'd1;
			idx_q <= idx_q + 1'b1;
			if ({1'b0, idx_q} == total - 7'd1) busy <= 1'b0;
		end
	end

	// Store write and the window of the most recent words.
	always_ff @(posedge clk) begin
		if (busy && !start) begin
			mem[idx_q] <= nw;
			prev_q <= nw;
			for (int i = 7; i > 0; i--) back_q[i] <= back_q[i-1];
			back_q[0] <= nw;
		end
	end

	always_ff @(posedge clk) rd_word <= mem[rd_addr];
endmodule

### hdl/aes_round.sv
`timescale 1ns / 1ps
module aes_round import aes_pkg::*; (
	input  logic clk,
	input  rnd_ctl_t ctl,
	input  logic [BlockW-1:0] blk_in,
	input  logic [BlockW-1:0] rkey,
	output logic [BlockW-1:0] state_q
);
	logic [7:0] s [16], a [16], m [16];
	logic [BlockW-1:0] nxt;

	function automatic logic [7:0] mul(input logic [7:0] x, input logic [3:0] c);
		logic [7:0] x2, x4, x8, r;
		x2 = xt(x); x4 = xt(x2); x8 = xt(x4);
		r = (c[0] ? x : 8'h0) ^ (c[1] ? x2 : 8'h0) ^ (c[2] ? x4 : 8'h0) ^ (c[3] ? x8 : 8'h0);
		return r;
	endfunction

	// One full round, forward or inverse, per cycle while stepping; the first step only adds the round key.
	always_comb begin
		for (int i = 0; i < 16; i++) s[i] = state_q[BlockW-1-8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				if (!ctl.decrypt)
					a[c*4+r] = SBOX[s[((c+r)%4)*4+r]];
				else
					a[c*4+r] = ISBOX[s[((c+4-r)%4)*4+r]] ^ rkey[BlockW-1-8*(c*4+r) -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				if (!ctl.decrypt)
					m[c*4+r] = mul(a[c*4+r], 4'h2) ^ mul(a[c*4+(r+1)%4], 4'h3)
						^ a[c*4+(r+2)%4] ^ a[c*4+(r+3)%4];
				else
					m[c*4+r] = mul(a[c*4+r], 4'he) ^ mul(a[c*4+(r+1)%4], 4'hb)
						^ mul(a[c*4+(r+2)%4], 4'hd) ^ mul(a[c*4+(r+3)%4], 4'h9);
		for (int i = 0; i < 16; i++) begin
			if (!ctl.decrypt)
				nxt[BlockW-1-8*i -: 8] = (ctl.last ? a[i] : m[i]) ^ rkey[BlockW-1-8*i -: 8];
			else
				nxt[BlockW-1-8*i -: 8] = ctl.last ? a[i] : m[i];
		end
		if (ctl.first) nxt = state_q ^ rkey;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) state_q <= blk_in;
		else if (ctl.step) state_q <= nxt;
	end
endmodule
